// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent check, off while reset is high
`define DFR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dfr assertion failed");

// check that applies only while a qualifier is high
`define DFR_ASSERT_WHEN(lbl, clk, rst, qual, prop) \
  `DFR_ASSERT(lbl, clk, rst, (qual) |-> (prop))

`endif

// ----- sv/dfr_pkg.sv -----
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int MAX_FRAME_BYTES = 2048;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W = 12;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);

  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_OK = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;
  localparam logic [1:0] KIND_OVF = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    OP_DATA,
    OP_END,
    OP_OVF
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] data;
    logic [LEN_W-1:0] len;
  } token_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
    token_t tok0;
    token_t tok1;
  } push_t;

  function automatic logic [LEN_W-1:0] len_of(input logic [COUNT_W-1:0] cnt);
    return LEN_W'(32'(cnt));
  endfunction

  function automatic token_t mk_tok(input op_t op, input logic [7:0] data,
                                    input logic [LEN_W-1:0] len);
    token_t t;
    t.op = op;
    t.data = data;
    t.len = len;
    return t;
  endfunction

endpackage

// ----- sv/dfr_front.sv -----
`timescale 1ns / 1ps

module dfr_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  input  logic space_ok,
  output dfr_pkg::push_t push
);

  typedef enum logic [1:0] {
    HUNT,
    START,
    BODY,
    HELD
  } phase_t;

  phase_t phase, phase_next;
  logic [dfr_pkg::COUNT_W-1:0] count, count_next;
  logic [dfr_pkg::COUNT_W-1:0] cnt1, cnt2;
  logic take;

  assign in_ready = space_ok;
  assign take = in_valid && space_ok;
  assign cnt1 = count + dfr_pkg::COUNT_W'(1);
  assign cnt2 = count + dfr_pkg::COUNT_W'(2);

  always_comb begin
    phase_next = phase;
    count_next = count;
    push = '0;
    if (take) begin
      unique case (phase)
        HUNT: begin
          if (in_byte == dfr_pkg::CH_BANG) phase_next = START;
        end
        START: begin
          count_next = '0;
          if (in_byte == dfr_pkg::CH_AMP) phase_next = BODY;
          else phase_next = HUNT;
        end
        BODY: begin
          if (in_byte == dfr_pkg::CH_BANG) begin
            phase_next = HELD;
          end else if (count >= dfr_pkg::MAX_COUNT) begin
            push.wr0 = 1'b1;
            push.tok0 = dfr_pkg::mk_tok(dfr_pkg::OP_OVF, 8'h00, '0);
            phase_next = HUNT;
            count_next = '0;
          end else begin
            push.wr0 = 1'b1;
            push.tok0 = dfr_pkg::mk_tok(dfr_pkg::OP_DATA, in_byte, dfr_pkg::len_of(cnt1));
            count_next = cnt1;
          end
        end
        HELD: begin
          if (in_byte == dfr_pkg::CH_HASH) begin
            push.wr0 = 1'b1;
            push.tok0 = dfr_pkg::mk_tok(dfr_pkg::OP_END, 8'h00, dfr_pkg::len_of(count));
            phase_next = HUNT;
            count_next = '0;
          end else if (count >= dfr_pkg::MAX_COUNT) begin
            push.wr0 = 1'b1;
            push.tok0 = dfr_pkg::mk_tok(dfr_pkg::OP_OVF, 8'h00, '0);
            phase_next = HUNT;
            count_next = '0;
          end else begin
            // held bang goes out as data first
            push.wr0 = 1'b1;
            push.tok0 = dfr_pkg::mk_tok(dfr_pkg::OP_DATA, dfr_pkg::CH_BANG,
                                        dfr_pkg::len_of(cnt1));
            if (in_byte == dfr_pkg::CH_BANG) begin
              count_next = cnt1;
            end else if (cnt1 >= dfr_pkg::MAX_COUNT) begin
              push.wr1 = 1'b1;
              push.tok1 = dfr_pkg::mk_tok(dfr_pkg::OP_OVF, 8'h00, '0);
              phase_next = HUNT;
              count_next = '0;
            end else begin
              push.wr1 = 1'b1;
              push.tok1 = dfr_pkg::mk_tok(dfr_pkg::OP_DATA, in_byte,
                                          dfr_pkg::len_of(cnt2));
              phase_next = BODY;
              count_next = cnt2;
            end
          end
        end
        default: phase_next = HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= HUNT;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

endmodule

// ----- sv/dfr_queue.sv -----
`timescale 1ns / 1ps

module dfr_queue (
  input  logic clk,
  input  logic rst,
  input  dfr_pkg::push_t push,
  input  logic pop,
  output logic space_ok,
  output logic nonempty,
  output dfr_pkg::token_t head
);

  dfr_pkg::token_t mem [dfr_pkg::QDEPTH];
  logic [dfr_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [dfr_pkg::QCNT_W-1:0] count;

  assign space_ok = count <= dfr_pkg::QCNT_W'(dfr_pkg::QDEPTH - 2);
  assign nonempty = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.wr0) mem[wr_ptr] <= push.tok0;
    if (push.wr1) mem[wr_ptr + dfr_pkg::QPTR_W'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + dfr_pkg::QPTR_W'(push.wr0) + dfr_pkg::QPTR_W'(push.wr1);
      rd_ptr <= rd_ptr + dfr_pkg::QPTR_W'(pop);
      count <= count + dfr_pkg::QCNT_W'(push.wr0) + dfr_pkg::QCNT_W'(push.wr1)
               - dfr_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ----- sv/dfr_back.sv -----
`timescale 1ns / 1ps

module dfr_back (
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  dfr_pkg::token_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic [11:0] frame_length,
  output logic [15:0] folded_sum,
  output logic frame_end
);

  logic [15:0] sum, sum_next;
  logic [7:0] low, low_next;
  logic low_valid, low_valid_next;
  logic [1:0] kind_next;
  logic [7:0] byte_next;
  logic [11:0] len_next;
  logic [15:0] fsum_next;
  logic end_next;
  logic [15:0] add_word;
  logic [16:0] wide;
  logic [15:0] folded;

  // end-around carry add of the pending word
  always_comb begin
    if (head.op == dfr_pkg::OP_DATA) add_word = {head.data, low};
    else add_word = {8'h00, low};
    wide = {1'b0, sum} + {1'b0, add_word};
    folded = wide[15:0] + 16'(wide[16]);
  end

  assign pop = nonempty && (!out_valid || out_ready);

  always_comb begin
    sum_next = sum;
    low_next = low;
    low_valid_next = low_valid;
    kind_next = dfr_pkg::KIND_PAYLOAD;
    byte_next = 8'h00;
    len_next = head.len;
    fsum_next = 16'h0000;
    end_next = 1'b0;
    unique case (head.op)
      dfr_pkg::OP_DATA: begin
        byte_next = head.data;
        if (low_valid) begin
          sum_next = folded;
          low_next = 8'h00;
          low_valid_next = 1'b0;
        end else begin
          low_next = head.data;
          low_valid_next = 1'b1;
        end
      end
      dfr_pkg::OP_END: begin
        fsum_next = low_valid ? folded : sum;
        kind_next = (fsum_next == dfr_pkg::SUM_ALL_ONES) ? dfr_pkg::KIND_OK
                                                          : dfr_pkg::KIND_BAD;
        end_next = 1'b1;
        sum_next = '0;
        low_next = '0;
        low_valid_next = 1'b0;
      end
      default: begin
        kind_next = dfr_pkg::KIND_OVF;
        len_next = dfr_pkg::len_of(dfr_pkg::MAX_COUNT);
        end_next = 1'b1;
        sum_next = '0;
        low_next = '0;
        low_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sum <= '0;
      low <= '0;
      low_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      sum <= sum_next;
      low <= low_next;
      low_valid <= low_valid_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind <= kind_next;
      payload_byte <= byte_next;
      frame_length <= len_next;
      folded_sum <= fsum_next;
      frame_end <= end_next;
    end
  end

endmodule

// ----- sv/delimited_frame_receiver_checksum_top.sv -----
`timescale 1ns / 1ps
// a result passes through the queue and then the output register after its input transfer
// throughput: one byte per cycle when in_ready, one result per cycle when out_ready
// a released '!' adds a second result, which the queue holds until the back end pops it
// the four-entry queue between parser and checksum unit sets the stall slack
// reset: synchronous, clears parse state, byte count, queue and running sum

module delimited_frame_receiver_checksum_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] kind,
  output logic [7:0] payload_byte,
  output logic [11:0] frame_length,
  output logic [15:0] folded_sum,
  output logic frame_end
);

  dfr_pkg::push_t push;
  dfr_pkg::token_t head;
  logic space_ok;
  logic nonempty;
  logic pop;

  dfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .space_ok (space_ok),
    .push     (push)
  );

  dfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .space_ok (space_ok),
    .nonempty (nonempty),
    .head     (head)
  );

  dfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (nonempty),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .folded_sum   (folded_sum),
    .frame_end    (frame_end)
  );

endmodule

// ----- sv/dfr_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dfr_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] kind,
  input logic [7:0] payload_byte,
  input logic [11:0] frame_length,
  input logic [15:0] folded_sum,
  input logic frame_end
);

  `DFR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(kind))
  `DFR_ASSERT_WHEN(a_end_kind, clk, rst, out_valid, frame_end == (kind != dfr_pkg::KIND_PAYLOAD))
  `DFR_ASSERT_WHEN(a_data_nosum, clk, rst, out_valid && !frame_end, folded_sum == 16'h0000)
  `DFR_ASSERT_WHEN(a_end_nobyte, clk, rst, out_valid && frame_end, payload_byte == 8'h00)
  `DFR_ASSERT_WHEN(a_ok_sum, clk, rst, out_valid && kind == dfr_pkg::KIND_OK, folded_sum == dfr_pkg::SUM_ALL_ONES)

endmodule

bind delimited_frame_receiver_checksum_top dfr_checker u_chk (.*);

// ----- tb/delimited_frame_receiver_checksum_top_tb.sv -----
`timescale 1ns / 1ps

module delimited_frame_receiver_checksum_top_tb;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 1600;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_START_BANG,
    PH_PAYLOAD,
    PH_HELD_BANG
  } rx_phase_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [11:0] len;
    logic [15:0] sum;
    logic last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [11:0] frame_length;
  logic [15:0] folded_sum;
  logic frame_end;

  rx_phase_t rx_phase = PH_HUNT;
  int unsigned rx_count = 0;
  logic [15:0] rx_sum = 16'h0000;
  logic [7:0] lo_byte = 8'h00;
  logic lo_pending = 1'b0;
  frame_result_t expected_q[$];

  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;

  delimited_frame_receiver_checksum_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .payload_byte(payload_byte),
    .frame_length(frame_length),
    .folded_sum(folded_sum),
    .frame_end(frame_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + 16'(s[16]);
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                      input logic [11:0] len, input logic [15:0] sum,
                                      input logic last);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.len = len;
    r.sum = sum;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void clear_frame();
    rx_count = 0;
    rx_sum = 16'h0000;
    lo_byte = 8'h00;
    lo_pending = 1'b0;
  endfunction

  // returns 0 when the byte overflows the frame and the frame is dropped
  function automatic bit take_payload(input logic [7:0] b);
    if (rx_count >= dfr_pkg::MAX_FRAME_BYTES) begin
      push_result(dfr_pkg::KIND_OVF, 8'h00, 12'(dfr_pkg::MAX_FRAME_BYTES), 16'h0000, 1'b1);
      clear_frame();
      rx_phase = PH_HUNT;
      return 1'b0;
    end
    rx_count++;
    if (lo_pending) begin
      rx_sum = ones_add(rx_sum, {b, lo_byte});
      lo_pending = 1'b0;
      lo_byte = 8'h00;
    end else begin
      lo_byte = b;
      lo_pending = 1'b1;
    end
    push_result(dfr_pkg::KIND_PAYLOAD, b, 12'(rx_count), 16'h0000, 1'b0);
    return 1'b1;
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    case (rx_phase)
      PH_HUNT: begin
        if (c == dfr_pkg::CH_BANG) rx_phase = PH_START_BANG;
      end
      PH_START_BANG: begin
        if (c == dfr_pkg::CH_AMP) begin
          clear_frame();
          rx_phase = PH_PAYLOAD;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        if (c == dfr_pkg::CH_BANG) rx_phase = PH_HELD_BANG;
        else void'(take_payload(c));
      end
      default: begin
        if (c == dfr_pkg::CH_HASH) begin
          if (lo_pending) rx_sum = ones_add(rx_sum, {8'h00, lo_byte});
          push_result((rx_sum == dfr_pkg::SUM_ALL_ONES) ? dfr_pkg::KIND_OK : dfr_pkg::KIND_BAD,
                      8'h00, 12'(rx_count), rx_sum, 1'b1);
          clear_frame();
          rx_phase = PH_HUNT;
        end else if (take_payload(dfr_pkg::CH_BANG) && c != dfr_pkg::CH_BANG) begin
          rx_phase = PH_PAYLOAD;
          void'(take_payload(c));
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_idle(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_byte(input bit markers);
    logic [7:0] b;
    int unsigned r;
    b = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (!markers) return (b == dfr_pkg::CH_BANG) ? 8'h20 : b;
    if (r == 0) return dfr_pkg::CH_BANG;
    if (r == 1) return ($urandom_range(0, 1) != 0) ? dfr_pkg::CH_AMP : dfr_pkg::CH_HASH;
    return b;
  endfunction

  // body must have even length; appends the word that makes the frame sum all ones
  function automatic void append_fix_word(ref logic [7:0] body[$]);
    logic [15:0] s;
    s = 16'h0000;
    for (int i = 0; i + 1 < body.size(); i += 2) s = ones_add(s, {body[i+1], body[i]});
    s = ~s;
    body.push_back(s[7:0]);
    body.push_back(s[15:8]);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    gap = pick_idle(src_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] body[$], input bit close);
    send_byte(dfr_pkg::CH_BANG);
    send_byte(dfr_pkg::CH_AMP);
    foreach (body[i]) send_byte(body[i]);
    if (close) begin
      send_byte(dfr_pkg::CH_BANG);
      send_byte(dfr_pkg::CH_HASH);
    end
  endtask

  task automatic report_error(input string msg);
    $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic test_directed_frames();
    logic [7:0] body[$];
    src_idle = 1'b1;
    snk_idle = 1'b1;
    body = '{8'h00, 8'hFF};
    send_frame(body, 1'b1);
    // empty frame
    body.delete();
    send_frame(body, 1'b1);
    // bang after start bang does not open a frame
    send_byte(dfr_pkg::CH_BANG);
    send_byte(dfr_pkg::CH_BANG);
    send_byte(dfr_pkg::CH_AMP);
    // held bangs released as data, odd length
    body = '{dfr_pkg::CH_BANG, dfr_pkg::CH_BANG, 8'h5A};
    send_frame(body, 1'b1);
    body = '{8'hFF, 8'hFF};
    send_frame(body, 1'b1);
  endtask

  task automatic test_overflow();
    logic [7:0] body[$];
    src_idle = 1'b1;
    snk_idle = 1'b1;
    // full size frame with a good sum
    body.delete();
    repeat (dfr_pkg::MAX_FRAME_BYTES - 2) body.push_back(pick_byte(1'b0));
    append_fix_word(body);
    send_frame(body, 1'b1);
    // one plain byte too many
    body.delete();
    repeat (dfr_pkg::MAX_FRAME_BYTES + 1) body.push_back(pick_byte(1'b0));
    send_frame(body, 1'b1);
    // released bang fills the frame, the byte after it overflows
    body.delete();
    repeat (dfr_pkg::MAX_FRAME_BYTES - 1) body.push_back(pick_byte(1'b0));
    body.push_back(dfr_pkg::CH_BANG);
    body.push_back(8'h41);
    send_frame(body, 1'b1);
    // bang after held bang on a full frame
    body.delete();
    repeat (dfr_pkg::MAX_FRAME_BYTES) body.push_back(pick_byte(1'b0));
    body.push_back(dfr_pkg::CH_BANG);
    body.push_back(dfr_pkg::CH_BANG);
    send_frame(body, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [7:0] body[$];
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      src_idle = ($urandom_range(0, 4) != 0);
      snk_idle = ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 6)) send_byte(pick_byte(1'b1));
      end else begin
        body.delete();
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        repeat (len) body.push_back(pick_byte(1'b1));
        if (r <= 4) begin
          if (body.size() % 2 != 0) body.push_back(pick_byte(1'b1));
          append_fix_word(body);
        end
        // an unclosed frame runs into the next one
        send_frame(body, r != 9);
        sent += body.size() + 4;
      end
    end
  endtask

  initial begin
    forever begin
      int unsigned stall;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_idle(snk_idle);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_q.pop_front();
        if (kind !== want.kind)
          report_error($sformatf("result %0d kind: got %0d, expected %0d",
                                 result_count, kind, want.kind));
        if (payload_byte !== want.data)
          report_error($sformatf("result %0d payload_byte: got %0h, expected %0h",
                                 result_count, payload_byte, want.data));
        if (frame_length !== want.len)
          report_error($sformatf("result %0d frame_length: got %0d, expected %0d",
                                 result_count, frame_length, want.len));
        if (folded_sum !== want.sum)
          report_error($sformatf("result %0d folded_sum: got %0h, expected %0h",
                                 result_count, folded_sum, want.sum));
        if (frame_end !== want.last)
          report_error($sformatf("result %0d frame_end: got %0b, expected %0b",
                                 result_count, frame_end, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_overflow();
    test_random_traffic();
    in_valid <= 1'b0;
    snk_idle = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
